FILE: sv/rpss_pkg.sv
// rpss_pkg: shared types, constants and codes for the resistive pad scan sequencer
`default_nettype none
package rpss_pkg;

    localparam int PAD_COUNT = 9;
    localparam int PAD_IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    localparam int ADC_W    = 10;
    localparam int MASK_W   = 9;
    localparam int SUM_W    = 11;
    localparam int PAD_W    = 4;
    localparam int PHASE_W  = 2;
    localparam int COUNT_W  = 2;
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 12;
    localparam int WANTED_W = 2;

    localparam logic [PHASE_W-1:0] PH_PLATE1 = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PLATE2 = 2'd1;
    localparam logic [PHASE_W-1:0] PH_X      = 2'd2;
    localparam logic [PHASE_W-1:0] PH_Y      = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PRESSURE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_X        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_Y        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VELOCITY = 3'd4;

    localparam logic [WANTED_W-1:0] WANT_SINGLE = 2'd1;
    localparam logic [WANTED_W-1:0] WANT_TRIPLE = 2'd3;

    localparam logic [COUNT_W-1:0] AVG_SAMPLES = 2'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_CLEARED = -12'sd1;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] count;
        logic [PAD_W-1:0]   pad;
        logic [SUM_W-1:0]   s0;
        logic [SUM_W-1:0]   s1;
        logic [SUM_W-1:0]   s2;
        logic [ADC_W-1:0]   plate;
    } scan_state_t;

    typedef struct packed {
        logic                vel_we;
        logic                vel_val;
        logic                want_we;
        logic [WANTED_W-1:0] want_val;
    } pad_update_t;

    typedef struct packed {
        logic [PHASE_W-1:0]        next_phase;
        logic [PAD_W-1:0]          mux_select;
        logic [KIND_W-1:0]         write_kind;
        logic [PAD_W-1:0]          write_pad;
        logic signed [VALUE_W-1:0] write_value;
    } result_t;

endpackage
`default_nettype wire

FILE: sv/rpss_step.sv
// rpss_step: next-state and result logic for one adc word
`default_nettype none
module rpss_step (
    input  rpss_pkg::scan_state_t           cur,
    input  logic [rpss_pkg::ADC_W-1:0]      adc,
    input  logic [rpss_pkg::MASK_W-1:0]     mask,
    input  logic [rpss_pkg::SUM_W-1:0]      threshold,
    input  logic                            vel_cur,
    input  logic [rpss_pkg::WANTED_W-1:0]   wanted_cur,
    output rpss_pkg::scan_state_t           nxt,
    output rpss_pkg::pad_update_t           upd,
    output rpss_pkg::result_t               res
);

    logic                          pressed;
    logic                          plate_phase;
    logic [rpss_pkg::SUM_W-1:0]    adc_ext;
    logic [rpss_pkg::SUM_W-1:0]    st0;
    logic [rpss_pkg::SUM_W-1:0]    st1;
    logic [rpss_pkg::SUM_W-1:0]    st2;
    logic [rpss_pkg::SUM_W-1:0]    mx01;
    logic [rpss_pkg::SUM_W-1:0]    mx;
    logic [rpss_pkg::SUM_W-1:0]    z;
    logic [rpss_pkg::SUM_W-1:0]    avg_sum;
    logic [rpss_pkg::COUNT_W-1:0]  count_inc;
    logic [rpss_pkg::PAD_W-1:0]    pad_inc;
    logic [rpss_pkg::PAD_W-1:0]    pad_adv;
    logic                          over;

    assign adc_ext     = {1'b0, adc};
    assign pressed     = ({1'b0, cur.pad} < 5'(rpss_pkg::MASK_W)) ? mask[cur.pad] : 1'b0;
    assign plate_phase = (cur.phase == rpss_pkg::PH_PLATE1) || (cur.phase == rpss_pkg::PH_PLATE2);
    assign st0 = (cur.count == 2'd0) ? adc_ext : cur.s0;
    assign st1 = (cur.count == 2'd1) ? adc_ext : cur.s1;
    assign st2 = (cur.count == 2'd2) ? adc_ext : cur.s2;
    assign mx01 = (st1 > st0) ? st1 : st0;
    assign mx   = (st2 > mx01) ? st2 : mx01;
    assign z    = {1'b0, cur.plate} + mx;
    assign over = z > threshold;
    assign avg_sum   = cur.s0 + adc_ext;
    assign count_inc = cur.count + 2'd1;
    assign pad_inc   = cur.pad + 4'd1;
    assign pad_adv   = ({1'b0, pad_inc} >= 5'(rpss_pkg::PAD_COUNT)) ? '0 : pad_inc;

    always_comb
    begin
        nxt = cur;
        upd = '0;
        res.write_kind  = rpss_pkg::KIND_NONE;
        res.write_pad   = '0;
        res.write_value = '0;
        if (plate_phase)
        begin
            nxt.s0    = st0;
            nxt.s1    = st1;
            nxt.s2    = st2;
            nxt.count = count_inc;
            if (count_inc == wanted_cur)
            begin
                nxt.count = '0;
                if (cur.phase == rpss_pkg::PH_PLATE1)
                begin
                    nxt.plate = st0[rpss_pkg::ADC_W-1:0];
                    nxt.phase = rpss_pkg::PH_PLATE2;
                end
                else
                begin
                    res.write_kind  = rpss_pkg::KIND_PRESSURE;
                    res.write_pad   = cur.pad;
                    res.write_value = {1'b0, z};
                    nxt.phase       = rpss_pkg::PH_PLATE1;
                    if (pressed)
                    begin
                        nxt.phase    = rpss_pkg::PH_X;
                        upd.vel_we   = 1'b1;
                        upd.vel_val  = 1'b0;
                        upd.want_we  = 1'b1;
                        upd.want_val = rpss_pkg::WANT_SINGLE;
                        nxt.s0       = '0;
                        nxt.s1       = '0;
                        nxt.s2       = '0;
                    end
                    else if (over && !vel_cur)
                    begin
                        res.write_value = rpss_pkg::VALUE_CLEARED;
                        upd.vel_we      = 1'b1;
                        upd.vel_val     = 1'b1;
                        upd.want_we     = 1'b1;
                        upd.want_val    = rpss_pkg::WANT_TRIPLE;
                    end
                    else if (over)
                    begin
                        res.write_kind = rpss_pkg::KIND_VELOCITY;
                    end
                    else
                    begin
                        upd.want_we  = 1'b1;
                        upd.want_val = rpss_pkg::WANT_SINGLE;
                        nxt.pad      = pad_adv;
                    end
                end
            end
        end
        else
        begin
            nxt.s0    = avg_sum;
            nxt.count = count_inc;
            if (count_inc == rpss_pkg::AVG_SAMPLES)
            begin
                res.write_kind  = (cur.phase == rpss_pkg::PH_X) ? rpss_pkg::KIND_X
                                                                 : rpss_pkg::KIND_Y;
                res.write_pad   = cur.pad;
                res.write_value = {2'b00, avg_sum[rpss_pkg::SUM_W-1:1]};
                nxt.count       = '0;
                nxt.s0          = '0;
                if (cur.phase == rpss_pkg::PH_X)
                begin
                    nxt.phase = rpss_pkg::PH_Y;
                end
                else
                begin
                    nxt.s1    = '0;
                    nxt.s2    = '0;
                    nxt.phase = rpss_pkg::PH_PLATE1;
                    nxt.pad   = pad_adv;
                end
            end
        end
        res.next_phase = nxt.phase;
        res.mux_select = nxt.pad;
    end

endmodule
`default_nettype wire

FILE: sv/resistive_pad_scan_sequencer_core.sv
// resistive_pad_scan_sequencer_core: top level of the resistive pad scan sequencer
// Takes one adc word per cycle together with the pad pressed mask and returns one result
// word for each: the next scan phase, the mux select and the value written, if any. Every
// word is handled by the combinational step logic, from the scan state registers into
// the output register, so the block sustains one word per clock; in_ready drops only while
// a result is held in the output register and out_ready is low. The threshold register is
// written through the cfg channel, which is always ready, and resets to zero.
`default_nettype none
module resistive_pad_scan_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpss_pkg::SUM_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rpss_pkg::ADC_W-1:0]          adc_sample,
    input  logic [rpss_pkg::MASK_W-1:0]         pad_pressed_mask,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rpss_pkg::PHASE_W-1:0]        next_phase,
    output logic [rpss_pkg::PAD_W-1:0]          mux_select,
    output logic [rpss_pkg::KIND_W-1:0]         write_kind,
    output logic [rpss_pkg::PAD_W-1:0]          write_pad,
    output logic signed [rpss_pkg::VALUE_W-1:0] write_value
);

    rpss_pkg::scan_state_t              state_reg;
    rpss_pkg::scan_state_t              state_next;
    rpss_pkg::pad_update_t              upd;
    rpss_pkg::result_t                  res_next;
    rpss_pkg::result_t                  res_reg;
    logic [rpss_pkg::SUM_W-1:0]         threshold_reg;
    logic                               out_valid_reg;
    logic                               vel_mode_reg [rpss_pkg::PAD_COUNT];
    logic [rpss_pkg::WANTED_W-1:0]      wanted_reg [rpss_pkg::PAD_COUNT];
    logic [rpss_pkg::PAD_IDX_W-1:0]     pad_idx;
    logic                               accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign pad_idx   = state_reg.pad[rpss_pkg::PAD_IDX_W-1:0];

    rpss_step u_step (
        .cur        (state_reg),
        .adc        (adc_sample),
        .mask       (pad_pressed_mask),
        .threshold  (threshold_reg),
        .vel_cur    (vel_mode_reg[pad_idx]),
        .wanted_cur (wanted_reg[pad_idx]),
        .nxt        (state_next),
        .upd        (upd),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            for (int i = 0; i < rpss_pkg::PAD_COUNT; i++)
            begin
                vel_mode_reg[i] <= 1'b0;
                wanted_reg[i]   <= rpss_pkg::WANT_SINGLE;
            end
        end
        else if (accept)
        begin
            state_reg <= state_next;
            if (upd.vel_we)
            begin
                vel_mode_reg[pad_idx] <= upd.vel_val;
            end
            if (upd.want_we)
            begin
                wanted_reg[pad_idx] <= upd.want_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_phase  = res_reg.next_phase;
    assign mux_select  = res_reg.mux_select;
    assign write_kind  = res_reg.write_kind;
    assign write_pad   = res_reg.write_pad;
    assign write_value = res_reg.write_value;

    a_idle_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_kind == rpss_pkg::KIND_NONE |-> write_pad == '0 && write_value == '0)
        else $error("result without a write carries a pad or value");

    a_x_then_y: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_kind == rpss_pkg::KIND_X |-> next_phase == rpss_pkg::PH_Y)
        else $error("x word not followed by y phase");

    a_avg_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == rpss_pkg::PH_X || state_reg.phase == rpss_pkg::PH_Y
        |-> state_reg.count < rpss_pkg::AVG_SAMPLES)
        else $error("averaging count out of range");

    a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.pad} < 5'(rpss_pkg::PAD_COUNT))
        else $error("current pad beyond pad count");

endmodule
`default_nettype wire
